// ----- sv/fpc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants of the frustum plane cull test block.
// ----------------------------------------------------------------------------
package fpc_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;

	localparam int NORM_FRAC   = 30;
	localparam int NUM_PLANES  = 6;
	localparam int MAG_W       = 33;
	localparam int SQ_W        = 66;
	localparam int X_W         = 126;
	localparam int ROOT_W      = 63;
	localparam int ROOT_STEPS  = 63;
	localparam int DIV_W       = 93;
	localparam int DIV_STEPS   = 93;
	localparam int OFS_W       = 48;
	localparam int ROW_W       = 3 * 32 + OFS_W;

	localparam logic signed [OFS_W-1:0] OFS_MAX   = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [63:0]      OFS_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_POINT  = 2'd1,
		REQ_SPHERE = 2'd2,
		REQ_BOX    = 2'd3
	} req_t;

	localparam logic [3:0] LAST_ELEM = 4'd15;

	typedef struct packed {
		logic       load;
		logic       mwr;
		logic       rd;
		logic [1:0] step;
		logic [2:0] plane;
		logic       sq;
		logic [1:0] sel;
		logic       sclr;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_store;
		logic       zero_store;
		logic       wb;
		logic       qrd;
		logic       out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic s_zero;
	} dp_sts_t;

endpackage

// ----- sv/fpc_req_if.sv -----
// ----------------------------------------------------------------------------
// fpc_req_if
// Request channel: matrix element writes and culling queries.
// ----------------------------------------------------------------------------
interface fpc_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [3:0]         elem_index;
	logic signed [31:0] elem_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic [30:0]        radius;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;
	logic signed [31:0] max_z;

	modport source (output valid, req_type, elem_index, elem_value, pos_x, pos_y, pos_z,
		radius, max_x, max_y, max_z, input ready);
	modport sink (input valid, req_type, elem_index, elem_value, pos_x, pos_y, pos_z,
		radius, max_x, max_y, max_z, output ready);
endinterface

// ----- sv/fpc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fpc_rsp_if
// Response channel: one inside/culled word per query.
// ----------------------------------------------------------------------------
interface fpc_rsp_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface

// ----- sv/fpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpc_ctrl
// Sequencer for plane extraction and query evaluation.
// ----------------------------------------------------------------------------
module fpc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        req_type,
	input  logic [3:0]        elem_index,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output fpc_pkg::dp_cmd_t  cmd,
	input  fpc_pkg::dp_sts_t  sts
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_SQ, ST_SQI, ST_SQRT, ST_CHK, ST_ZERO,
		ST_DINI, ST_DIV, ST_DST, ST_WB, ST_QRUN, ST_QDONE
	} state_t;

	state_t     state_q;
	logic [6:0] cnt_q;
	logic [2:0] plane_q;
	logic [1:0] sel_q;
	logic       out_valid_q;
	logic       accept;
	logic       is_write;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_write  = (req_type == fpc_pkg::REQ_WRITE);
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.plane = plane_q;
		cmd.sel   = sel_q;
		cmd.step  = cnt_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				cmd.mwr  = accept && is_write;
			end
			ST_RD: begin
				cmd.rd   = (cnt_q < 7'd4);
				cmd.sclr = (cnt_q == 7'd0);
			end
			ST_SQ: begin
				cmd.sq  = (cnt_q < 7'd3);
				cmd.sel = cnt_q[1:0];
			end
			ST_SQI:   cmd.sqrt_init = 1'b1;
			ST_SQRT:  cmd.sqrt_step = 1'b1;
			ST_CHK:   cmd.load      = 1'b0;
			ST_ZERO:  cmd.zero_store = 1'b1;
			ST_DINI:  cmd.div_init  = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_DST:   cmd.div_store = 1'b1;
			ST_WB:    cmd.wb        = 1'b1;
			ST_QRUN: begin
				cmd.qrd   = (cnt_q < 7'(fpc_pkg::NUM_PLANES));
				cmd.plane = cnt_q[2:0];
			end
			ST_QDONE: cmd.out_load = out_free;
			default:  cmd.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			plane_q     <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_QDONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					plane_q <= '0;
					if (accept) begin
						if (!is_write) state_q <= ST_QRUN;
						else if (elem_index == fpc_pkg::LAST_ELEM) state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (cnt_q == 7'd4) begin
						cnt_q   <= '0;
						state_q <= ST_SQ;
					end else cnt_q <= cnt_q + 7'd1;
				end
				ST_SQ: begin
					if (cnt_q == 7'd3) state_q <= ST_SQI;
					else cnt_q <= cnt_q + 7'd1;
				end
				ST_SQI: begin
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == 7'(fpc_pkg::ROOT_STEPS - 1)) state_q <= ST_CHK;
					else cnt_q <= cnt_q + 7'd1;
				end
				ST_CHK: begin
					sel_q   <= '0;
					state_q <= sts.s_zero ? ST_ZERO : ST_DINI;
				end
				ST_ZERO: state_q <= ST_WB;
				ST_DINI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 7'(fpc_pkg::DIV_STEPS - 1)) state_q <= ST_DST;
					else cnt_q <= cnt_q + 7'd1;
				end
				ST_DST: begin
					if (sel_q == 2'd3) state_q <= ST_WB;
					else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_DINI;
					end
				end
				ST_WB: begin
					cnt_q <= '0;
					if (plane_q == 3'(fpc_pkg::NUM_PLANES - 1)) state_q <= ST_IDLE;
					else begin
						plane_q <= plane_q + 3'd1;
						state_q <= ST_RD;
					end
				end
				ST_QRUN: begin
					if (cnt_q == 7'd7) state_q <= ST_QDONE;
					else cnt_q <= cnt_q + 7'd1;
				end
				ST_QDONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/fpc_dp.sv -----
// ----------------------------------------------------------------------------
// fpc_dp
// Datapath: matrix and plane stores, square/sqrt/divide units, plane tests.
// ----------------------------------------------------------------------------
module fpc_dp #(
	parameter int COORD_WIDTH = fpc_pkg::DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = fpc_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fpc_pkg::dp_cmd_t   cmd,
	output fpc_pkg::dp_sts_t   sts,
	input  logic [1:0]         req_type,
	input  logic [3:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [30:0]        radius,
	input  logic signed [31:0] max_x,
	input  logic signed [31:0] max_y,
	input  logic signed [31:0] max_z,
	output logic               inside_res
);

	localparam int SW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int SH = fpc_pkg::NORM_FRAC - FRAC_BITS;
	localparam int MW = fpc_pkg::MAG_W;
	localparam int RW = fpc_pkg::ROOT_W;
	localparam int XW = fpc_pkg::X_W;
	localparam int DW = fpc_pkg::DIV_W;
	localparam int OW = fpc_pkg::OFS_W;

	// matrix store
	logic signed [31:0] mat_mem [16];
	logic [15:0]        mat_vld_q;
	logic signed [31:0] elem_s;
	logic [3:0]         ra, rb;
	logic signed [31:0] ma_s1, mb_s1, a_val, b_val;
	logic               mav_s1, mbv_s1, rd_v_s1, minus_s1;
	logic [1:0]         rd_step_s1;
	logic signed [MW-1:0] ab_sum;
	logic signed [MW-1:0] c_q [3];
	logic signed [MW-1:0] d_q;

	assign elem_s = 32'($signed(elem_value[SW-1:0]));
	assign ra     = {cmd.step, 2'b11};
	assign rb     = {cmd.step, cmd.plane[2:1]};

	always_ff @(posedge clk) begin
		if (cmd.mwr) mat_mem[elem_index] <= elem_s;
		if (cmd.rd) begin
			ma_s1 <= mat_mem[ra];
			mb_s1 <= mat_mem[rb];
		end
		rd_step_s1 <= cmd.step;
		minus_s1   <= cmd.plane[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_vld_q <= '0;
			rd_v_s1   <= 1'b0;
			mav_s1    <= 1'b0;
			mbv_s1    <= 1'b0;
		end else begin
			if (cmd.mwr) mat_vld_q[elem_index] <= 1'b1;
			rd_v_s1 <= cmd.rd;
			mav_s1  <= mat_vld_q[ra];
			mbv_s1  <= mat_vld_q[rb];
		end
	end

	assign a_val  = mav_s1 ? ma_s1 : '0;
	assign b_val  = mbv_s1 ? mb_s1 : '0;
	assign ab_sum = minus_s1 ? (MW'(a_val) - MW'(b_val)) : (MW'(a_val) + MW'(b_val));

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (rd_step_s1 == 2'd3) d_q <= ab_sum;
			else c_q[rd_step_s1] <= ab_sum;
		end
	end

	// sum of squares
	logic signed [MW-1:0] c_sel;
	logic [MW-1:0]        c_mag;
	logic [fpc_pkg::SQ_W-1:0] sq_s1, s_q;
	logic                 sqv_s1;

	assign c_sel = c_q[cmd.sel];
	assign c_mag = c_sel[MW-1] ? MW'(-c_sel) : MW'(c_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sqv_s1 <= 1'b0;
		else sqv_s1 <= cmd.sq;
	end

	always_ff @(posedge clk) begin
		if (cmd.sq) sq_s1 <= fpc_pkg::SQ_W'(c_mag) * fpc_pkg::SQ_W'(c_mag);
		if (cmd.sclr) s_q <= '0;
		else if (sqv_s1) s_q <= s_q + sq_s1;
	end

	assign sts.s_zero = (s_q == '0);

	// digit-by-digit square root of s * 2^60
	logic [XW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [RW+3:0] srem_q, rem_sh, trial;
	logic          sge;

	assign rem_sh = {srem_q[RW+1:0], x_q[XW-1:XW-2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign sge    = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			x_q    <= {s_q, 60'd0};
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.sqrt_step) begin
			srem_q <= sge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], sge};
			x_q    <= {x_q[XW-3:0], 2'b00};
		end
	end

	// restoring divider, quotient = |v| * 2^60 / root
	logic signed [MW-1:0] dv;
	logic [MW-1:0]        dv_mag;
	logic [DW-1:0]        num_q, quo_q;
	logic [RW-1:0]        drem_q;
	logic [RW:0]          rem2, den;
	logic                 dge, dneg_q;
	logic signed [31:0]   nq;
	logic signed [OW-1:0] qs;
	logic signed [OW-1:0] ofs_q;
	logic signed [31:0]   nrm_q [3];
	logic signed [63:0]   dsh;
	logic signed [OW-1:0] zofs;

	assign dv     = (cmd.sel == 2'd3) ? d_q : c_q[cmd.sel];
	assign dv_mag = dv[MW-1] ? MW'(-dv) : MW'(dv);
	assign rem2   = {drem_q, num_q[DW-1]};
	assign den    = {1'b0, root_q};
	assign dge    = (rem2 >= den);
	assign nq     = {1'b0, quo_q[30:0]};
	assign qs     = (|quo_q[DW-1:OW-1]) ? fpc_pkg::OFS_MAX : {1'b0, quo_q[OW-2:0]};
	assign dsh    = 64'(d_q) <<< SH;

	always_comb begin
		if (dsh > fpc_pkg::OFS_MAX64) zofs = fpc_pkg::OFS_MAX;
		else if (dsh < -fpc_pkg::OFS_MAX64) zofs = -fpc_pkg::OFS_MAX;
		else zofs = dsh[OW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			num_q  <= {dv_mag, 60'd0};
			drem_q <= '0;
			quo_q  <= '0;
			dneg_q <= dv[MW-1];
		end else if (cmd.div_step) begin
			drem_q <= dge ? RW'(rem2 - den) : rem2[RW-1:0];
			quo_q  <= {quo_q[DW-2:0], dge};
			num_q  <= {num_q[DW-2:0], 1'b0};
		end
		if (cmd.div_store) begin
			if (cmd.sel == 2'd3) ofs_q <= dneg_q ? -qs : qs;
			else nrm_q[cmd.sel] <= dneg_q ? -nq : nq;
		end
		if (cmd.zero_store) begin
			nrm_q[0] <= '0;
			nrm_q[1] <= '0;
			nrm_q[2] <= '0;
			ofs_q    <= zofs;
		end
	end

	// plane store
	logic [fpc_pkg::ROW_W-1:0] row_mem [fpc_pkg::NUM_PLANES];
	logic [fpc_pkg::NUM_PLANES-1:0] row_vld_q;
	logic [fpc_pkg::ROW_W-1:0] row_s1, row_e;
	logic                      rowv_s1, qv_s1, qv_s2;

	always_ff @(posedge clk) begin
		if (cmd.wb) row_mem[cmd.plane] <= {ofs_q, nrm_q[2], nrm_q[1], nrm_q[0]};
		if (cmd.qrd) row_s1 <= row_mem[cmd.plane];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rowv_s1   <= 1'b0;
			qv_s1     <= 1'b0;
			qv_s2     <= 1'b0;
		end else begin
			if (cmd.wb) row_vld_q[cmd.plane] <= 1'b1;
			rowv_s1 <= row_vld_q[cmd.plane];
			qv_s1   <= cmd.qrd;
			qv_s2   <= qv_s1;
		end
	end

	// query evaluation
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic signed [63:0] extra_q;
	logic               box_q, inside_q, res_q;
	logic signed [31:0] n_e [3];
	logic signed [31:0] v_e [3];
	logic signed [63:0] prod_s2 [3];
	logic signed [OW:0] nofs_s2;
	logic signed [63:0] dot, fl;

	assign row_e = rowv_s1 ? row_s1 : '0;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			n_e[j] = row_e[32*j +: 32];
			v_e[j] = (box_q && !n_e[j][31]) ? hi_q[j] : lo_q[j];
		end
	end

	assign dot = extra_q + prod_s2[0] + prod_s2[1] + prod_s2[2];
	assign fl  = dot >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q[0] <= 32'($signed(pos_x[SW-1:0]));
			lo_q[1] <= 32'($signed(pos_y[SW-1:0]));
			lo_q[2] <= 32'($signed(pos_z[SW-1:0]));
			hi_q[0] <= 32'($signed(max_x[SW-1:0]));
			hi_q[1] <= 32'($signed(max_y[SW-1:0]));
			hi_q[2] <= 32'($signed(max_z[SW-1:0]));
			box_q   <= (req_type == fpc_pkg::REQ_BOX);
			extra_q <= (req_type == fpc_pkg::REQ_SPHERE) ?
				{3'b000, radius, 30'd0} : '0;
		end
		if (qv_s1) begin
			for (int j = 0; j < 3; j++) prod_s2[j] <= 64'(n_e[j]) * 64'(v_e[j]);
			nofs_s2 <= -((OW+1)'(signed'(row_e[fpc_pkg::ROW_W-1 -: OW])));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b1;
			res_q    <= 1'b1;
		end else begin
			if (cmd.load) inside_q <= 1'b1;
			else if (qv_s2 && (fl < 64'(nofs_s2))) inside_q <= 1'b0;
			if (cmd.out_load) res_q <= inside_q;
		end
	end

	assign inside_res = res_q;

endmodule

// ----- sv/frustum_plane_cull_test_top.sv -----
// ----------------------------------------------------------------------------
// frustum_plane_cull_test_top
// View-frustum plane extraction from a view-projection matrix and culling.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per item: a matrix element write (req_type 0) or a
//   point, sphere or box query. rsp returns one inside_res word per query;
//   writes return nothing.
//   An element write is taken and req stays ready, except for element 15:
//   that write starts plane extraction, which runs one plane at a time
//   through a shared squarer, a 63-step square root and a 93-step divider,
//   with req not ready until all six planes are done.
//   A query tests the six planes through a three-stage read/multiply/compare
//   pipeline; the result is on rsp and req is ready again in the same cycle,
//   so a new query is taken only once the last one's result is on rsp.
//   rsp holds its word until taken; a finished query waits while rsp is full.
//   Reset clears the matrix and all planes to zero, so every query reports
//   inside until a matrix is loaded.
// ----------------------------------------------------------------------------
module frustum_plane_cull_test_top #(
	parameter int COORD_WIDTH = fpc_pkg::DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = fpc_pkg::DEF_FRAC_BITS
) (
	input logic        clk,
	input logic        arst_n,
	fpc_req_if.sink    req,
	fpc_rsp_if.source  rsp
);

	fpc_pkg::dp_cmd_t cmd;
	fpc_pkg::dp_sts_t sts;

	fpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.req_type   (req.req_type),
		.elem_index (req.elem_index),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	fpc_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req.req_type),
		.elem_index (req.elem_index),
		.elem_value (req.elem_value),
		.pos_x      (req.pos_x),
		.pos_y      (req.pos_y),
		.pos_z      (req.pos_z),
		.radius     (req.radius),
		.max_x      (req.max_x),
		.max_y      (req.max_y),
		.max_z      (req.max_z),
		.inside_res (rsp.inside_res)
	);

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type != fpc_pkg::REQ_WRITE) |=> !req.ready)
		else $error("request taken while a query is in flight");

	a_extract_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.req_type == fpc_pkg::REQ_WRITE &&
		req.elem_index == fpc_pkg::LAST_ELEM) |=> !req.ready)
		else $error("request taken during plane extraction");

	a_rsp_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("response raised without a query in flight");

endmodule
